/* src/idf_pkg.sv */
package idf_pkg;

   localparam int CHAR_W         = 7;
   localparam int GROUP_MAX      = 6;
   localparam int GROUP_CNT_W    = 3;
   localparam int QUEUE_DEPTH_DEF = 4;

   typedef struct packed {
      logic [7:0] name_byte;
      logic       byte_valid;
      logic       name_end;
   } req_word_type;

   typedef struct packed {
      logic [CHAR_W-1:0] out_char;
      logic              out_last;
   } rsp_word_type;

   // Characters one input word releases, oldest in slot 0.
   typedef struct packed {
      logic [GROUP_MAX-1:0][CHAR_W-1:0] chars;
      logic [GROUP_CNT_W-1:0]           count;
      logic                             ends;
   } group_type;

endpackage

/* src/idf_front.sv */
module idf_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  idf_pkg::req_word_type req_word,
   input  logic                 q_full,
   output logic                 q_push,
   output idf_pkg::group_type   q_group
);
   import idf_pkg::*;

   typedef enum logic [1:0] {
      LEAD_NONE = 2'd0,
      LEAD_C3   = 2'd1,
      LEAD_C4   = 2'd2,
      LEAD_C5   = 2'd3
   } lead_type;

   localparam logic [CHAR_W-1:0] CHAR_K  = 7'h6B;
   localparam logic [CHAR_W-1:0] CHAR_US = 7'h5F;
   localparam logic [CHAR_W-1:0] CHAR_NONE = 7'h00;
   localparam logic [7:0]        LEAD_BASE = 8'hC2;

   lead_type              held_ff, held_in;
   logic                  emitted_ff, emitted_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [CHAR_W-1:0]     pend_char_ff, pend_char_in;

   logic                  accept;
   logic [CHAR_W-1:0]     chr_list [GROUP_MAX];
   logic [GROUP_CNT_W-1:0] n;
   logic                  em;
   lead_type              held;
   logic [CHAR_W-1:0]     fold_char;
   logic [CHAR_W-1:0]     fresh_char;
   logic                  fresh_lead;
   logic                  fresh_digit;
   logic                  need_fresh;
   logic [7:0]            lead_diff;
   logic [7:0]            b;

   function automatic logic [CHAR_W-1:0] fold_pair(lead_type lead, logic [7:0] t);
      logic [CHAR_W-1:0] f;
      f = CHAR_NONE;
      case (lead)
         LEAD_C3: begin
            if (t == 8'hBC || t == 8'h9C) f = 7'h75;
            else if (t == 8'hB6 || t == 8'h96) f = 7'h6F;
            else if (t == 8'hA7 || t == 8'h87) f = 7'h63;
         end
         LEAD_C4: begin
            if (t == 8'hB1 || t == 8'hB0) f = 7'h69;
            else if (t == 8'h9F || t == 8'h9E) f = 7'h67;
         end
         LEAD_C5: begin
            if (t == 8'h9F || t == 8'h9E) f = 7'h73;
         end
         default: f = CHAR_NONE;
      endcase
      return f;
   endfunction

   assign accept = req_push && !q_full;
   assign b      = req_word.name_byte;

   // Classify the byte as if no lead were held, and fold it against the held lead.
   always_comb begin
      lead_diff   = b - LEAD_BASE;
      fresh_lead  = (b >= 8'hC3) && (b <= 8'hC5);
      fresh_digit = (b >= 8'h30) && (b <= 8'h39);
      if (b >= 8'h41 && b <= 8'h5A) begin
         fresh_char = b[CHAR_W-1:0] + 7'h20;
      end else if ((b >= 8'h61 && b <= 8'h7A) || fresh_digit) begin
         fresh_char = b[CHAR_W-1:0];
      end else begin
         fresh_char = CHAR_US;
      end
      fold_char  = fold_pair(held_ff, b);
   end

   always_comb begin
      for (int i = 0; i < GROUP_MAX; i++) chr_list[i] = CHAR_NONE;
      n    = '0;
      em   = emitted_ff;
      held = held_ff;
      need_fresh = req_word.byte_valid && (held_ff == LEAD_NONE || fold_char == CHAR_NONE);

      if (pend_valid_ff) begin
         chr_list[n] = pend_char_ff;
         n = n + 1'b1;
      end
      if (req_word.byte_valid && held_ff != LEAD_NONE) begin
         chr_list[n] = (fold_char != CHAR_NONE) ? fold_char : CHAR_US;
         n    = n + 1'b1;
         em   = 1'b1;
         held = LEAD_NONE;
      end
      if (need_fresh) begin
         if (fresh_lead) begin
            held = lead_type'(lead_diff[1:0]);
         end else begin
            if (!em && fresh_digit) begin
               chr_list[n] = CHAR_K;
               n = n + 1'b1;
            end
            chr_list[n] = fresh_char;
            n  = n + 1'b1;
            em = 1'b1;
         end
      end
      if (req_word.name_end) begin
         // flush a lead byte that never got its trail
         if (held != LEAD_NONE) begin
            chr_list[n] = CHAR_US;
            n  = n + 1'b1;
            em = 1'b1;
         end
         if (!em) begin
            chr_list[0] = 7'h6B;
            chr_list[1] = 7'h61;
            chr_list[2] = 7'h74;
            chr_list[3] = 7'h6D;
            chr_list[4] = 7'h61;
            chr_list[5] = 7'h6E;
            n = GROUP_CNT_W'(GROUP_MAX);
         end
      end

      for (int i = 0; i < GROUP_MAX; i++) q_group.chars[i] = chr_list[i];
      q_group.ends = req_word.name_end;

      if (req_word.name_end) begin
         q_group.count = n;
         held_in       = LEAD_NONE;
         emitted_in    = 1'b0;
         pend_valid_in = 1'b0;
         pend_char_in  = CHAR_NONE;
      end else begin
         // hold back the newest character until we know whether it is last
         q_group.count = (n == '0) ? '0 : n - 1'b1;
         held_in       = held;
         emitted_in    = em;
         pend_valid_in = (n != '0);
         pend_char_in  = (n != '0) ? chr_list[n - 1'b1] : pend_char_ff;
      end
      q_push = accept && (q_group.count != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff       <= LEAD_NONE;
         emitted_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else if (accept) begin
         held_ff       <= held_in;
         emitted_ff    <= emitted_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_char_ff <= pend_char_in;
      end
   end

endmodule

/* src/idf_queue.sv */
module idf_queue #(
   parameter int DEPTH = idf_pkg::QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_push,
   input  idf_pkg::group_type q_group,
   input  logic               q_pop,
   output idf_pkg::group_type q_head,
   output logic               q_full,
   output logic               q_empty
);
   import idf_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   group_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign q_full  = (cnt_ff == CNT_FULL);
   assign q_empty = (cnt_ff == '0);
   assign q_head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (q_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (q_push && !q_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (q_pop && !q_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         slot_ff[wr_ptr_ff] <= q_group;
      end
   end

endmodule

/* src/idf_back.sv */
module idf_back (
   input  logic                  clock,
   input  logic                  reset,
   input  idf_pkg::group_type    q_head,
   input  logic                  q_empty,
   output logic                  q_pop,
   output idf_pkg::rsp_word_type rsp_word,
   output logic                  rsp_empty,
   input  logic                  rsp_pop
);
   import idf_pkg::*;

   logic [GROUP_CNT_W-1:0] idx_ff, idx_in;
   logic                   out_valid_ff, out_valid_in;
   rsp_word_type           out_word_ff, out_word_in;
   logic                   load;
   logic                   at_tail;

   assign rsp_empty = !out_valid_ff;
   assign rsp_word  = out_word_ff;

   always_comb begin
      load    = !q_empty && (!out_valid_ff || rsp_pop);
      at_tail = (idx_ff == q_head.count - 1'b1);
      q_pop   = load && at_tail;
      idx_in  = idx_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_word_in  = out_word_ff;
      if (load) begin
         out_valid_in         = 1'b1;
         out_word_in.out_char = q_head.chars[idx_ff];
         out_word_in.out_last = q_head.ends && at_tail;
         // advance through the group, drop it after its final character
         idx_in = at_tail ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_word_ff <= out_word_in;
   end

endmodule

/* src/identifier_folder.sv */
// Identifier folder: turns a UTF-8 name, pushed one word per byte, into a safe lower-case
// SQL identifier over [a-z0-9_], popped one character per word with out_last on the final
// one. Turkish two-byte letters fold to ASCII, upper case is lowered, other bytes become
// '_', a leading digit gets a 'k' in front and an empty name yields "katman". The newest
// character is held back until the next word shows whether the name ends there. A word is
// accepted every cycle while the group queue (QUEUE_DEPTH entries) has room; the output
// stage delivers one character per cycle while rsp_pop keeps it drained, and a word
// releases up to six characters, for an empty name. A character is registered in the queue
// slot and then in the output register before it appears on the result ports.
module identifier_folder #(
   parameter int QUEUE_DEPTH = idf_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  idf_pkg::req_word_type req_word,
   output logic                  req_full,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output idf_pkg::rsp_word_type rsp_word
);
   import idf_pkg::*;

   logic      q_push;
   logic      q_pop;
   logic      q_full;
   logic      q_empty;
   group_type q_group;
   group_type q_head;

   assign req_full = q_full;

   idf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_word (req_word),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_group  (q_group)
   );

   idf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_group (q_group),
      .q_pop   (q_pop),
      .q_head  (q_head),
      .q_full  (q_full),
      .q_empty (q_empty)
   );

   idf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_head    (q_head),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_word  (rsp_word),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

   a_reset_clear: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("outputs not cleared after reset");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_push)
      else $error("group pushed into a full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("group popped from an empty queue");

   a_back_loads: assert property (@(posedge clock) disable iff (reset)
      !q_empty && rsp_empty |=> !rsp_empty)
      else $error("output stage idle while groups wait");

endmodule
